>>> hdl/renc_pkg.sv
// Shared types, codes and decode tables for the rotary encoder unit.
// No dependencies.
package renc_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_KIND  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FAST  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SLOW  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PRESS = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HOLD  = 3'd4;

  // Input word opcodes
  localparam logic OP_PIN  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // step_event codes
  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_CW   = 2'd1;
  localparam logic [1:0] STEP_CCW  = 2'd2;

  // Table entry direction field, bits [5:4]
  localparam logic [1:0] DIR_CW  = 2'b01;
  localparam logic [1:0] DIR_CCW = 2'b10;

  localparam logic [2:0] KIND0_START = 3'd0;
  localparam logic [2:0] KIND1_START = 3'd6;

  localparam logic [7:0] SAT_MAX = 8'd255;

  localparam logic [7:0] RST_FAST  = 8'd10;
  localparam logic [7:0] RST_SLOW  = 8'd50;
  localparam logic [7:0] RST_PRESS = 8'd2;
  localparam logic [7:0] RST_HOLD  = 8'd25;

  // {dir[1:0], next_state[2:0]} padded to 6 bits, indexed [state][{a,b}]
  localparam logic [5:0] ENC_TBL_GEN [8][4] = '{
    '{6'h00, 6'h02, 6'h04, 6'h00},
    '{6'h03, 6'h00, 6'h01, 6'h10},
    '{6'h03, 6'h02, 6'h00, 6'h00},
    '{6'h03, 6'h02, 6'h01, 6'h00},
    '{6'h06, 6'h00, 6'h04, 6'h00},
    '{6'h06, 6'h05, 6'h00, 6'h20},
    '{6'h06, 6'h05, 6'h04, 6'h00},
    '{6'h00, 6'h02, 6'h04, 6'h00}
  };

  localparam logic [5:0] ENC_TBL_ALT [8][4] = '{
    '{6'h00, 6'h01, 6'h02, 6'h00},
    '{6'h13, 6'h01, 6'h01, 6'h00},
    '{6'h23, 6'h02, 6'h02, 6'h00},
    '{6'h03, 6'h05, 6'h04, 6'h03},
    '{6'h03, 6'h04, 6'h04, 6'h10},
    '{6'h03, 6'h05, 6'h05, 6'h20},
    '{6'h03, 6'h06, 6'h06, 6'h00},
    '{6'h03, 6'h06, 6'h06, 6'h00}
  };

  typedef struct packed {
    logic       kind;
    logic [7:0] fast_limit;
    logic [7:0] slow_limit;
    logic [7:0] press_ticks;
    logic [7:0] hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] step_event;
    logic       dir;
    logic       fast;
    logic       slow;
  } enc_res_t;

  typedef struct packed {
    logic down;
    logic long_hold;
    logic event_p;
  } btn_res_t;

endpackage

>>> hdl/rotary_encoder_with_speed_and_button_unit.sv
// Top level of the rotary encoder unit: input register, config, result register.
// Depends on renc_pkg, renc_quad and renc_button.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  op, contact_a, contact_b, button_level
//   out_     output     out_valid/out_stall step_event, flags, button_event
//   cfg_     input      cfg_we             cfg_index, cfg_data
//
// One word per cycle while out_ does not stall.
// The table step and counters run between the input and result registers.
// A stall on out_ holds the result and passes back to in_stall only once
// the input register is also full. Synchronous active-low reset.
module rotary_encoder_with_speed_and_button_unit import renc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_op,
  input  logic                in_contact_a,
  input  logic                in_contact_b,
  input  logic                in_button_level,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_step_event,
  output logic                out_last_clockwise,
  output logic                out_fast_turn,
  output logic                out_slow_turn,
  output logic                out_button_down,
  output logic                out_button_long,
  output logic                out_button_event,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t       cfg_r;
  logic       s1_valid_r;
  logic       s1_op_r, s1_a_r, s1_b_r, s1_btn_r;
  logic       out_valid_r;
  enc_res_t   out_enc_r;
  btn_res_t   out_btn_r;
  enc_res_t   enc_res;
  btn_res_t   btn_res;
  logic       out_free, fire, accept, kind_load;

  assign out_free  = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign accept    = in_valid && !in_stall;
  assign kind_load = cfg_we && (cfg_index == CFG_KIND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{kind: 1'b0, fast_limit: RST_FAST, slow_limit: RST_SLOW,
                 press_ticks: RST_PRESS, hold_ticks: RST_HOLD};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KIND:  cfg_r.kind        <= cfg_data[0];
        CFG_FAST:  cfg_r.fast_limit  <= cfg_data;
        CFG_SLOW:  cfg_r.slow_limit  <= cfg_data;
        CFG_PRESS: cfg_r.press_ticks <= cfg_data;
        CFG_HOLD:  cfg_r.hold_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) s1_valid_r <= 1'b1;
      else if (fire) s1_valid_r <= 1'b0;
      if (out_free) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r  <= in_op;
      s1_a_r   <= in_contact_a;
      s1_b_r   <= in_contact_b;
      s1_btn_r <= in_button_level;
    end
    if (fire) begin
      out_enc_r <= enc_res;
      out_btn_r <= btn_res;
    end
  end

  renc_quad u_quad (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .kind_load     (kind_load),
    .kind_load_val (cfg_data[0]),
    .fire          (fire),
    .op            (s1_op_r),
    .contact_a     (s1_a_r),
    .contact_b     (s1_b_r),
    .res           (enc_res)
  );

  renc_button u_button (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .fire         (fire),
    .op           (s1_op_r),
    .button_level (s1_btn_r),
    .res          (btn_res)
  );

  assign out_valid          = out_valid_r;
  assign out_step_event     = out_enc_r.step_event;
  assign out_last_clockwise = out_enc_r.dir;
  assign out_fast_turn      = out_enc_r.fast;
  assign out_slow_turn      = out_enc_r.slow;
  assign out_button_down    = out_btn_r.down;
  assign out_button_long    = out_btn_r.long_hold;
  assign out_button_event   = out_btn_r.event_p;

`ifndef SYNTHESIS
  a_step_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_step_event != 2'd3))
    else $error("illegal step code");

  a_cw_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_step_event == STEP_CW) |-> out_last_clockwise)
    else $error("clockwise detent without direction flag");

  a_ccw_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_step_event == STEP_CCW) |-> !out_last_clockwise)
    else $error("counter-clockwise detent with direction flag");

  a_btn_evt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_button_event) |-> (out_button_down || out_button_long))
    else $error("button event without a raised flag");
`endif

endmodule

>>> hdl/renc_quad.sv
// Quadrature state engine with detent speed classification.
// Depends on renc_pkg.
module renc_quad import renc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     kind_load,
  input  logic     kind_load_val,
  input  logic     fire,
  input  logic     op,
  input  logic     contact_a,
  input  logic     contact_b,
  output enc_res_t res
);

  logic [2:0] state_r, state_nxt;
  logic [7:0] gap_r, gap_nxt;
  logic       dir_r, dir_nxt;
  logic       fast_r, fast_nxt;
  logic       slow_r, slow_nxt;
  logic [5:0] entry;
  logic [1:0] pins;
  logic [1:0] step;

  assign pins  = {contact_a, contact_b};
  // unused code 7 rows match each table's start behavior, so no remap needed
  assign entry = cfg.kind ? ENC_TBL_ALT[state_r][pins] : ENC_TBL_GEN[state_r][pins];

  always_comb begin
    state_nxt = state_r;
    gap_nxt   = gap_r;
    dir_nxt   = dir_r;
    fast_nxt  = fast_r;
    slow_nxt  = slow_r;
    step      = STEP_NONE;
    if (op == OP_PIN) begin
      state_nxt = entry[2:0];
      if (entry[5:4] == DIR_CW || entry[5:4] == DIR_CCW) begin
        dir_nxt  = (entry[5:4] == DIR_CW);
        step     = dir_nxt ? STEP_CW : STEP_CCW;
        fast_nxt = (gap_r <= cfg.fast_limit);
        slow_nxt = (gap_r >= cfg.slow_limit);
        gap_nxt  = 8'd0;
      end
    end else if (gap_r != SAT_MAX) begin
      gap_nxt = gap_r + 8'd1;
    end
  end

  assign res = '{step_event: step, dir: dir_nxt, fast: fast_nxt, slow: slow_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= KIND0_START;
      gap_r   <= 8'd0;
      dir_r   <= 1'b0;
      fast_r  <= 1'b0;
      slow_r  <= 1'b0;
    end else if (kind_load) begin
      state_r <= kind_load_val ? KIND1_START : KIND0_START;
    end else if (fire) begin
      state_r <= state_nxt;
      gap_r   <= gap_nxt;
      dir_r   <= dir_nxt;
      fast_r  <= fast_nxt;
      slow_r  <= slow_nxt;
    end
  end

endmodule

>>> hdl/renc_button.sv
// Pushbutton sampler: every fourth tick feeds a saturating press timer.
// Depends on renc_pkg.
module renc_button import renc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     fire,
  input  logic     op,
  input  logic     button_level,
  output btn_res_t res
);

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] timer_r, timer_nxt;
  logic       down_r, down_nxt;
  logic       long_r, long_nxt;
  logic       evt;

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    down_nxt  = down_r;
    long_nxt  = long_r;
    evt       = 1'b0;
    if (op == OP_TICK) begin
      phase_nxt = phase_r + 2'd1;
      if (phase_nxt == 2'd0) begin
        if (button_level) begin
          if (timer_r != SAT_MAX) timer_nxt = timer_r + 8'd1;
          if (cfg.press_ticks != 8'd0 && timer_nxt == cfg.press_ticks) begin
            down_nxt = 1'b1;
            evt      = 1'b1;
          end
          if (cfg.hold_ticks != 8'd0 && timer_nxt == cfg.hold_ticks) begin
            long_nxt = 1'b1;
            evt      = 1'b1;
          end
        end else begin
          timer_nxt = 8'd0;
          down_nxt  = 1'b0;
          long_nxt  = 1'b0;
        end
      end
    end
  end

  assign res = '{down: down_nxt, long_hold: long_nxt, event_p: evt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      timer_r <= 8'd0;
      down_r  <= 1'b0;
      long_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      down_r  <= down_nxt;
      long_r  <= long_nxt;
    end
  end

endmodule

>>> verif/rotary_encoder_with_speed_and_button_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for rotary_encoder_with_speed_and_button_unit: a directed
// table, then random quadrature walks and button tick runs across several settings.
// Depends on renc_pkg and the unit under hdl/.
module rotary_encoder_with_speed_and_button_unit_test;
  import renc_pkg::*;

  localparam int IDLE_LIMIT = 500;
  localparam int SHOWN_MAX = 10;
  localparam int N_DIRECTED = 25;
  localparam logic [2:0] UNUSED_STATE = 3'd7;

  typedef struct packed {
    logic op;
    logic contact_a;
    logic contact_b;
    logic button_level;
  } enc_word_t;

  typedef struct packed {
    logic [1:0] step_event;
    logic       last_cw;
    logic       fast;
    logic       slow;
    logic       down;
    logic       long_hold;
    logic       btn_event;
  } enc_result_t;

  typedef struct packed {
    enc_word_t   word;
    logic        typed;
    enc_result_t result;
  } vector_t;

  localparam enc_result_t QUIET = '0;

  // Gray walk of {a,b}; stepping +1 turns clockwise, +3 counter-clockwise
  localparam logic [1:0] WALK [4] = '{2'b11, 2'b01, 2'b00, 2'b10};

  // Decode tables indexed [state][{a,b}]
  localparam logic [2:0] GEN_NEXT [8][4] = '{
    '{3'd0, 3'd2, 3'd4, 3'd0}, '{3'd3, 3'd0, 3'd1, 3'd0},
    '{3'd3, 3'd2, 3'd0, 3'd0}, '{3'd3, 3'd2, 3'd1, 3'd0},
    '{3'd6, 3'd0, 3'd4, 3'd0}, '{3'd6, 3'd5, 3'd0, 3'd0},
    '{3'd6, 3'd5, 3'd4, 3'd0}, '{3'd0, 3'd2, 3'd4, 3'd0}
  };
  localparam logic [1:0] GEN_STEP [8][4] = '{
    '{STEP_NONE, STEP_NONE, STEP_NONE, STEP_NONE},
    '{STEP_NONE, STEP_NONE, STEP_NONE, STEP_CW},
    '{STEP_NONE, STEP_NONE, STEP_NONE, STEP_NONE},
    '{STEP_NONE, STEP_NONE, STEP_NONE, STEP_NONE},
    '{STEP_NONE, STEP_NONE, STEP_NONE, STEP_NONE},
    '{STEP_NONE, STEP_NONE, STEP_NONE, STEP_CCW},
    '{STEP_NONE, STEP_NONE, STEP_NONE, STEP_NONE},
    '{STEP_NONE, STEP_NONE, STEP_NONE, STEP_NONE}
  };
  localparam logic [2:0] ALT_NEXT [8][4] = '{
    '{3'd0, 3'd1, 3'd2, 3'd0}, '{3'd3, 3'd1, 3'd1, 3'd0},
    '{3'd3, 3'd2, 3'd2, 3'd0}, '{3'd3, 3'd5, 3'd4, 3'd3},
    '{3'd3, 3'd4, 3'd4, 3'd0}, '{3'd3, 3'd5, 3'd5, 3'd0},
    '{3'd3, 3'd6, 3'd6, 3'd0}, '{3'd3, 3'd6, 3'd6, 3'd0}
  };
  localparam logic [1:0] ALT_STEP [8][4] = '{
    '{STEP_NONE, STEP_NONE, STEP_NONE, STEP_NONE},
    '{STEP_CW,   STEP_NONE, STEP_NONE, STEP_NONE},
    '{STEP_CCW,  STEP_NONE, STEP_NONE, STEP_NONE},
    '{STEP_NONE, STEP_NONE, STEP_NONE, STEP_NONE},
    '{STEP_NONE, STEP_NONE, STEP_NONE, STEP_CW},
    '{STEP_NONE, STEP_NONE, STEP_NONE, STEP_CCW},
    '{STEP_NONE, STEP_NONE, STEP_NONE, STEP_NONE},
    '{STEP_NONE, STEP_NONE, STEP_NONE, STEP_NONE}
  };

  // Reset config: a clockwise detent, a press, a counter-clockwise detent,
  // release, then a bounce and an aborted turn.
  localparam vector_t DIRECTED [N_DIRECTED] = '{
    '{'{OP_TICK, 1'b0, 1'b0, 1'b1}, 1'b1, QUIET},
    '{'{OP_PIN,  1'b1, 1'b1, 1'b0}, 1'b1, QUIET},
    '{'{OP_PIN,  1'b0, 1'b1, 1'b1}, 1'b0, QUIET},
    '{'{OP_PIN,  1'b0, 1'b0, 1'b0}, 1'b0, QUIET},
    '{'{OP_PIN,  1'b1, 1'b0, 1'b1}, 1'b0, QUIET},
    '{'{OP_PIN,  1'b1, 1'b1, 1'b0}, 1'b1,
      '{STEP_CW, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_TICK, 1'b1, 1'b1, 1'b1}, 1'b0, QUIET},
    '{'{OP_TICK, 1'b0, 1'b1, 1'b1}, 1'b0, QUIET},
    '{'{OP_TICK, 1'b1, 1'b0, 1'b1}, 1'b0, QUIET},
    '{'{OP_TICK, 1'b0, 1'b0, 1'b1}, 1'b0, QUIET},
    '{'{OP_TICK, 1'b1, 1'b1, 1'b1}, 1'b0, QUIET},
    '{'{OP_TICK, 1'b0, 1'b1, 1'b1}, 1'b0, QUIET},
    '{'{OP_TICK, 1'b1, 1'b0, 1'b1}, 1'b1,
      '{STEP_NONE, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1}},
    '{'{OP_PIN,  1'b1, 1'b0, 1'b0}, 1'b0, QUIET},
    '{'{OP_PIN,  1'b0, 1'b0, 1'b1}, 1'b0, QUIET},
    '{'{OP_PIN,  1'b0, 1'b1, 1'b0}, 1'b0, QUIET},
    '{'{OP_PIN,  1'b1, 1'b1, 1'b1}, 1'b0, QUIET},
    '{'{OP_TICK, 1'b0, 1'b0, 1'b0}, 1'b0, QUIET},
    '{'{OP_TICK, 1'b1, 1'b1, 1'b0}, 1'b0, QUIET},
    '{'{OP_TICK, 1'b0, 1'b1, 1'b0}, 1'b0, QUIET},
    '{'{OP_TICK, 1'b1, 1'b0, 1'b0}, 1'b0, QUIET},
    '{'{OP_PIN,  1'b0, 1'b0, 1'b0}, 1'b0, QUIET},
    '{'{OP_PIN,  1'b0, 1'b1, 1'b1}, 1'b0, QUIET},
    '{'{OP_PIN,  1'b1, 1'b1, 1'b0}, 1'b0, QUIET},
    '{'{OP_TICK, 1'b1, 1'b1, 1'b0}, 1'b0, QUIET}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_op = 1'b0;
  logic                in_contact_a = 1'b0;
  logic                in_contact_b = 1'b0;
  logic                in_button_level = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_step_event;
  logic                out_last_clockwise;
  logic                out_fast_turn;
  logic                out_slow_turn;
  logic                out_button_down;
  logic                out_button_long;
  logic                out_button_event;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  rotary_encoder_with_speed_and_button_unit u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state and register mirror
  logic       kind_sel = 1'b0;
  logic [7:0] fast_lim = RST_FAST;
  logic [7:0] slow_lim = RST_SLOW;
  logic [7:0] press_lim = RST_PRESS;
  logic [7:0] hold_lim = RST_HOLD;
  logic [2:0] quad_state = KIND0_START;
  logic [1:0] tick_ph = '0;
  logic [7:0] gap_ticks = '0;
  logic [7:0] btn_timer = '0;
  logic       down_q = 1'b0;
  logic       long_q = 1'b0;
  logic       cw_q = 1'b0;
  logic       fast_q = 1'b0;
  logic       slow_q = 1'b0;

  enc_result_t expected_q [$];
  enc_result_t want;
  enc_result_t got;

  int  mismatches = 0;
  int  results_seen = 0;
  int  words_sent = 0;
  int  detents = 0;
  int  button_events = 0;
  int  settings_used = 1;
  int  idle_cycles = 0;
  int  stall_left = 0;
  int  pin_pos = 0;
  bit  gaps_on = 1'b0;
  bit  stall_on = 1'b0;
  logic btn_level = 1'b0;

  function automatic enc_result_t decode_word(enc_word_t w);
    enc_result_t r;
    logic [2:0]  row;
    logic [1:0]  pins;
    logic [1:0]  step;
    r = '0;
    step = STEP_NONE;
    if (w.op == OP_PIN) begin
      pins = {w.contact_a, w.contact_b};
      row = quad_state;
      if (row == UNUSED_STATE) row = kind_sel ? KIND1_START : KIND0_START;
      if (kind_sel) begin
        quad_state = ALT_NEXT[row][pins];
        step = ALT_STEP[row][pins];
      end else begin
        quad_state = GEN_NEXT[row][pins];
        step = GEN_STEP[row][pins];
      end
      if (step != STEP_NONE) begin
        cw_q = (step == STEP_CW);
        fast_q = (gap_ticks <= fast_lim);
        slow_q = (gap_ticks >= slow_lim);
        gap_ticks = '0;
        detents++;
      end
    end else begin
      tick_ph = tick_ph + 2'd1;
      // button is sampled on every fourth tick only
      if (tick_ph == 2'd0) begin
        if (w.button_level) begin
          if (btn_timer != SAT_MAX) btn_timer = btn_timer + 8'd1;
          if (press_lim != 0 && btn_timer == press_lim) begin
            down_q = 1'b1;
            r.btn_event = 1'b1;
          end
          if (hold_lim != 0 && btn_timer == hold_lim) begin
            long_q = 1'b1;
            r.btn_event = 1'b1;
          end
        end else begin
          btn_timer = '0;
          down_q = 1'b0;
          long_q = 1'b0;
        end
      end
      if (gap_ticks != SAT_MAX) gap_ticks = gap_ticks + 8'd1;
    end
    if (r.btn_event) button_events++;
    r.step_event = step;
    r.last_cw = cw_q;
    r.fast = fast_q;
    r.slow = slow_q;
    r.down = down_q;
    r.long_hold = long_q;
    return r;
  endfunction

  task automatic send_word(input enc_word_t w, input logic typed, input enc_result_t typed_res);
    enc_result_t predicted;
    if (gaps_on && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= w.op;
    in_contact_a <= w.contact_a;
    in_contact_b <= w.contact_b;
    in_button_level <= w.button_level;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = decode_word(w);
    expected_q.push_back(typed ? typed_res : predicted);
    words_sent++;
  endtask

  task automatic send_pins();
    enc_word_t w;
    w = {OP_PIN, WALK[pin_pos], 1'($urandom_range(0, 1))};
    send_word(w, 1'b0, QUIET);
  endtask

  task automatic send_tick(input logic lvl);
    enc_word_t w;
    w = {OP_TICK, 2'($urandom_range(0, 3)), lvl};
    send_word(w, 1'b0, QUIET);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_KIND: begin
        kind_sel = data[0];
        quad_state = kind_sel ? KIND1_START : KIND0_START;
      end
      CFG_FAST:  fast_lim = data;
      CFG_SLOW:  slow_lim = data;
      CFG_PRESS: press_lim = data;
      CFG_HOLD:  hold_lim = data;
      default: ;
    endcase
  endtask

  // Writes every register, then junk to the unused indexes, with the unit idle
  task automatic program_regs(input logic kind, input logic [7:0] fast, input logic [7:0] slow,
                              input logic [7:0] press, input logic [7:0] hold);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_write(CFG_KIND, {7'd0, kind});
    cfg_write(CFG_FAST, fast);
    cfg_write(CFG_SLOW, slow);
    cfg_write(CFG_PRESS, press);
    cfg_write(CFG_HOLD, hold);
    for (int i = CFG_HOLD + 1; i < 2**CfgIdxW; i++)
      cfg_write(i[CfgIdxW-1:0], 8'($urandom_range(0, 255)));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly clean quadrature turns and steady button runs, some contact noise
  task automatic run_random(input int n);
    int start;
    int pick;
    int len;
    int turn;
    start = words_sent;
    while (words_sent - start < n) begin
      if ($urandom_range(0, 49) == 0) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        turn = $urandom_range(0, 1) ? 1 : 3;
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 6) == 0) turn = 4 - turn;
          pin_pos = (pin_pos + turn) % 4;
          send_pins();
        end
      end else if (pick < 80) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) len = $urandom_range(1, 12);
        else if (pick < 95) len = $urandom_range(13, 70);
        else len = $urandom_range(100, 300);
        if ($urandom_range(0, 2) == 0) btn_level = ~btn_level;
        repeat (len) send_tick(btn_level);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3)) begin
          pin_pos = $urandom_range(0, 3);
          send_pins();
        end
      end else begin
        repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [1:0] exp_v, input logic [1:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      if (mismatches <= SHOWN_MAX)
        $display("result %0d: %s expected %0d, got %0d", results_seen, name, exp_v, got_v);
    end
  endtask

  // Result checker, stall generator and activity tracking
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {out_step_event, out_last_clockwise, out_fast_turn, out_slow_turn,
             out_button_down, out_button_long, out_button_event};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display("result %0d arrived with no word pending", results_seen);
      end else begin
        want = expected_q.pop_front();
        check_field("step_event", want.step_event, got.step_event);
        check_field("last_clockwise", want.last_cw, got.last_cw);
        check_field("fast_turn", want.fast, got.fast);
        check_field("slow_turn", want.slow, got.slow);
        check_field("button_down", want.down, got.down);
        check_field("button_long", want.long_hold, got.long_hold);
        check_field("button_event", want.btn_event, got.btn_event);
      end
      results_seen++;
    end
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (stall_left != 0) stall_left--;
    else if (stall_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 19);
    out_stall <= (stall_left != 0);
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("no word moved for %0d cycles", IDLE_LIMIT);
    $display("rotary_encoder_with_speed_and_button_unit_test failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    gaps_on = 1'b1;
    stall_on = 1'b1;
    for (int i = 0; i < N_DIRECTED; i++)
      send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].result);
    drain_results();
    run_random(200);

    program_regs(1'b1, 8'd0, 8'd255, 8'd1, 8'd255);
    run_random(200);

    gaps_on = 1'b0;
    stall_on = 1'b0;
    program_regs(1'b1, 8'd255, 8'd0, 8'd255, 8'd1);
    run_random(200);

    // zero thresholds never fire
    gaps_on = 1'b1;
    stall_on = 1'b1;
    program_regs(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd0, 8'd0);
    run_random(200);

    // Timer and detent gap both saturate; both flags re-fire on every sample
    program_regs(1'b0, 8'd0, 8'd255, 8'd255, 8'd255);
    repeat (4 * 256 + 8) send_tick(1'b1);
    pin_pos = 0;
    send_pins();
    repeat (4) begin
      pin_pos = (pin_pos + 1) % 4;
      send_pins();
    end
    repeat (4) begin
      pin_pos = (pin_pos + 3) % 4;
      send_pins();
    end
    repeat (4) send_tick(1'b0);

    gaps_on = 1'b0;
    stall_on = 1'b0;
    program_regs(1'($urandom_range(0, 1)), 8'($urandom_range(0, 20)), 8'($urandom_range(20, 60)),
                 8'($urandom_range(1, 8)), 8'($urandom_range(9, 30)));
    run_random(300);

    drain_results();
    repeat (8) @(posedge clk);
    $display("%0d words, %0d results checked: %0d detents, %0d button events, %0d settings",
             words_sent, results_seen, detents, button_events, settings_used);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("rotary_encoder_with_speed_and_button_unit_test passed");
    else
      $display("rotary_encoder_with_speed_and_button_unit_test failed");
    $finish;
  end

endmodule
